### src/scpq_pkg.sv
// Package for the sorted cost priority queue: sizes, operation and status codes,
// and the per-cycle command that the top level broadcasts to every cell.
// No dependencies.
package scpq_pkg;

	localparam int DEPTH    = 64;
	localparam int KEY_BITS = 32;
	localparam int ID_BITS  = 16;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		MODE_PUSH   = 3'd0,
		MODE_POP    = 3'd1,
		MODE_TOP    = 3'd2,
		MODE_SECOND = 3'd3,
		MODE_CLEAR  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2
	} status_t;

	// Command shared by all cells in one cycle.
	typedef struct packed {
		logic push;
		logic pop;
	} cell_cmd_t;

endpackage

### src/scpq_cell.sv
// One slot of the sorted chain: holds a key and an edge id and trades them
// with its neighbors on push (shift toward the tail) and pop (shift toward the head).
// Depends on scpq_pkg.
module scpq_cell
	import scpq_pkg::*;
(
	input  logic                clk,
	input  cell_cmd_t           cmd,
	input  logic                occ,
	input  logic [KEY_BITS-1:0] new_key,
	input  logic [ID_BITS-1:0]  new_edge,
	input  logic                left_gt,
	input  logic [KEY_BITS-1:0] left_key,
	input  logic [ID_BITS-1:0]  left_edge,
	input  logic [KEY_BITS-1:0] right_key,
	input  logic [ID_BITS-1:0]  right_edge,
	output logic                gt,
	output logic [KEY_BITS-1:0] key,
	output logic [ID_BITS-1:0]  edge_id
);

	logic [KEY_BITS-1:0] key_q;
	logic [ID_BITS-1:0]  edge_q;

	// An empty slot counts as holding a greater key, so a push lands there.
	assign gt      = !occ || (new_key < key_q);
	assign key     = key_q;
	assign edge_id = edge_q;

	always_ff @(posedge clk) begin
		if (cmd.push && gt) begin
			// The insertion point is the first slot that sees a greater key;
			// every slot after it takes its left neighbor.
			if (left_gt) begin
				key_q  <= left_key;
				edge_q <= left_edge;
			end else begin
				key_q  <= new_key;
				edge_q <= new_edge;
			end
		end else if (cmd.pop) begin
			key_q  <= right_key;
			edge_q <= right_edge;
		end
	end

endmodule

### src/sorted_cost_priority_queue_unit.sv
// Top level of the sorted cost priority queue: a chain of scpq_cell slots,
// the fill count and the registered result stage. Depends on scpq_pkg, scpq_cell.
//
// Usage:
// The input channel (in_valid, in_stall) carries one item per operation:
// mode, key_in and edge_in. Push inserts (key_in, edge_in) after all stored
// entries with a key less than or equal to key_in; pop removes the head; read
// top and read second report the first two entries; clear empties the queue.
// Every item yields exactly one result item on the output channel
// (out_valid, out_stall): key_out, edge_out, count and status.
// Every slot compares its key with the pushed key in the same cycle, and on a
// push the slots from the insertion point on shift one place. The result
// appears in the output register in the cycle after the item is taken, and
// the block takes one item per cycle as long as the receiver keeps up.
// When the receiver stalls, the result holds in the output register and the
// block stalls its input only while that register is full and not drained.
// Reset empties the queue (count zero) and the output register; slot
// contents are not cleared and are never read before being written.
module sorted_cost_priority_queue_unit
	import scpq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          mode,
	input  logic [KEY_BITS-1:0] key_in,
	input  logic [ID_BITS-1:0]  edge_in,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [KEY_BITS-1:0] key_out,
	output logic [ID_BITS-1:0]  edge_out,
	output logic [CNT_BITS-1:0] count,
	output logic [1:0]          status
);

	logic [CNT_BITS-1:0] fill_q;
	logic                out_valid_q;
	logic [KEY_BITS-1:0] key_out_q;
	logic [ID_BITS-1:0]  edge_out_q;
	logic [CNT_BITS-1:0] count_q;
	status_t             status_q;

	logic                accept;
	cell_cmd_t           cmd;
	logic [CNT_BITS-1:0] fill_d;
	logic [KEY_BITS-1:0] key_d;
	logic [ID_BITS-1:0]  edge_d;
	status_t             status_d;

	logic [DEPTH-1:0]    gt;
	logic [DEPTH-1:0]    occ;
	logic [KEY_BITS-1:0] cell_key  [DEPTH];
	logic [ID_BITS-1:0]  cell_edge [DEPTH];

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic                lgt;
			logic [KEY_BITS-1:0] lkey;
			logic [ID_BITS-1:0]  ledge;
			logic [KEY_BITS-1:0] rkey;
			logic [ID_BITS-1:0]  redge;

			assign occ[gi] = CNT_BITS'(gi) < fill_q;

			if (gi == 0) begin : g_head
				assign lgt   = 1'b0;
				assign lkey  = '0;
				assign ledge = '0;
			end else begin : g_mid
				assign lgt   = gt[gi-1];
				assign lkey  = cell_key[gi-1];
				assign ledge = cell_edge[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_tail
				assign rkey  = '0;
				assign redge = '0;
			end else begin : g_body
				assign rkey  = cell_key[gi+1];
				assign redge = cell_edge[gi+1];
			end

			scpq_cell u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.occ        (occ[gi]),
				.new_key    (key_in),
				.new_edge   (edge_in),
				.left_gt    (lgt),
				.left_key   (lkey),
				.left_edge  (ledge),
				.right_key  (rkey),
				.right_edge (redge),
				.gt         (gt[gi]),
				.key        (cell_key[gi]),
				.edge_id    (cell_edge[gi])
			);
		end
	endgenerate

	always_comb begin
		cmd      = '0;
		fill_d   = fill_q;
		key_d    = '0;
		edge_d   = '0;
		status_d = ST_OK;
		case (mode_t'(mode))
			MODE_PUSH: begin
				if (fill_q == CNT_BITS'(DEPTH)) begin
					status_d = ST_OVER;
				end else begin
					cmd.push = accept;
					fill_d   = fill_q + 1'b1;
				end
			end
			MODE_POP: begin
				if (fill_q == '0) begin
					status_d = ST_UNDER;
				end else begin
					cmd.pop = accept;
					fill_d  = fill_q - 1'b1;
					key_d   = cell_key[0];
					edge_d  = cell_edge[0];
				end
			end
			MODE_TOP: begin
				if (fill_q == '0) begin
					status_d = ST_UNDER;
				end else begin
					key_d  = cell_key[0];
					edge_d = cell_edge[0];
				end
			end
			MODE_SECOND: begin
				if (fill_q < CNT_BITS'(2)) begin
					status_d = ST_UNDER;
				end else begin
					key_d  = cell_key[1];
					edge_d = cell_edge[1];
				end
			end
			MODE_CLEAR: begin
				fill_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q      <= fill_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_out_q  <= key_d;
			edge_out_q <= edge_d;
			count_q    <= fill_d;
			status_q   <= status_d;
		end
	end

	assign out_valid = out_valid_q;
	assign key_out   = key_out_q;
	assign edge_out  = edge_out_q;
	assign count     = count_q;
	assign status    = status_q;

endmodule

### dv/tb_sorted_cost_priority_queue_unit.sv
// Self-checking testbench for sorted_cost_priority_queue_unit: directed and random
// push, pop, read and clear items against a sorted-list shadow of the queue.
// Depends on scpq_pkg and the RTL of the block.
module tb_sorted_cost_priority_queue_unit;
	import scpq_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;

	// Mode codes that the block ignores.
	localparam logic [2:0] MODE_IGNORED_5 = 3'd5;
	localparam logic [2:0] MODE_IGNORED_7 = 3'd7;

	typedef enum int {
		MIX_BALANCED,
		MIX_FILL,
		MIX_DRAIN,
		MIX_PUSH_ONLY
	} op_mix_e;

	typedef struct {
		logic [KEY_BITS-1:0] key;
		logic [ID_BITS-1:0] id;
		logic [CNT_BITS-1:0] cnt;
		logic [1:0] st;
	} reply_t;

	class sorted_queue_shadow;
		logic [KEY_BITS-1:0] keys[DEPTH];
		logic [ID_BITS-1:0] ids[DEPTH];
		int fill;
		int errors;
		reply_t expected_replies[$];

		function new();
			fill = 0;
			errors = 0;
		endfunction

		function void predict_reply(logic [2:0] op, logic [KEY_BITS-1:0] k,
				logic [ID_BITS-1:0] id);
			reply_t r;
			int i;
			r.key = '0;
			r.id = '0;
			r.st = ST_OK;
			case (op)
				MODE_PUSH: begin
					if (fill >= DEPTH) begin
						r.st = ST_OVER;
					end else begin
						// Walk from the tail so equal keys stay in arrival order.
						i = fill - 1;
						while (i >= 0 && k < keys[i]) begin
							keys[i + 1] = keys[i];
							ids[i + 1] = ids[i];
							i--;
						end
						keys[i + 1] = k;
						ids[i + 1] = id;
						fill++;
					end
				end
				MODE_POP: begin
					if (fill == 0) begin
						r.st = ST_UNDER;
					end else begin
						r.key = keys[0];
						r.id = ids[0];
						for (i = 1; i < fill; i++) begin
							keys[i - 1] = keys[i];
							ids[i - 1] = ids[i];
						end
						fill--;
					end
				end
				MODE_TOP: begin
					if (fill == 0) begin
						r.st = ST_UNDER;
					end else begin
						r.key = keys[0];
						r.id = ids[0];
					end
				end
				MODE_SECOND: begin
					if (fill < 2) begin
						r.st = ST_UNDER;
					end else begin
						r.key = keys[1];
						r.id = ids[1];
					end
				end
				MODE_CLEAR: begin
					fill = 0;
				end
				default: begin
				end
			endcase
			r.cnt = CNT_BITS'(fill);
			expected_replies.insert(expected_replies.size(), r);
		endfunction

		function void check_reply(logic [KEY_BITS-1:0] k, logic [ID_BITS-1:0] id,
				logic [CNT_BITS-1:0] cnt, logic [1:0] st);
			reply_t r;
			if (expected_replies.size() == 0) begin
				$error("unexpected result: key_out %0h edge_out %0h count %0d status %0d",
					k, id, cnt, st);
				errors++;
				return;
			end
			r = expected_replies.pop_front();
			if (k !== r.key) begin
				$error("field key_out: expected %0h, got %0h", r.key, k);
				errors++;
			end
			if (id !== r.id) begin
				$error("field edge_out: expected %0h, got %0h", r.id, id);
				errors++;
			end
			if (cnt !== r.cnt) begin
				$error("field count: expected %0d, got %0d", r.cnt, cnt);
				errors++;
			end
			if (st !== r.st) begin
				$error("field status: expected %0d, got %0d", r.st, st);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] mode = MODE_PUSH;
	logic [KEY_BITS-1:0] key_in = '0;
	logic [ID_BITS-1:0] edge_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [KEY_BITS-1:0] key_out;
	logic [ID_BITS-1:0] edge_out;
	logic [CNT_BITS-1:0] count;
	logic [1:0] status;

	int idle_pct = 0;
	int stall_pct = 0;
	int cycles = 0;
	sorted_queue_shadow shadow;

	sorted_cost_priority_queue_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.key_in(key_in),
		.edge_in(edge_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.key_out(key_out),
		.edge_out(edge_out),
		.count(count),
		.status(status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				shadow.predict_reply(mode, key_in, edge_in);
			if (out_valid && !out_stall)
				shadow.check_reply(key_out, edge_out, count, status);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_op(input logic [2:0] op, input logic [KEY_BITS-1:0] k,
			input logic [ID_BITS-1:0] id);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		key_in <= k;
		edge_in <= id;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (shadow.expected_replies.size() != 0);
	endtask

	function automatic logic [KEY_BITS-1:0] pick_key();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2, 3: return KEY_BITS'($urandom_range(7));
			default: return KEY_BITS'($urandom());
		endcase
	endfunction

	function automatic logic [2:0] pick_op(op_mix_e mix);
		int r;
		r = $urandom_range(99);
		if (mix == MIX_PUSH_ONLY)
			return MODE_PUSH;
		if (r < 2)
			return 3'($urandom_range(MODE_IGNORED_7, MODE_IGNORED_5));
		case (mix)
			MIX_FILL: begin
				if (r < 82) return MODE_PUSH;
				if (r < 90) return MODE_POP;
				if (r < 95) return MODE_TOP;
				return MODE_SECOND;
			end
			MIX_DRAIN: begin
				if (r < 20) return MODE_PUSH;
				if (r < 75) return MODE_POP;
				if (r < 88) return MODE_TOP;
				return MODE_SECOND;
			end
			default: begin
				if (r < 5) return MODE_CLEAR;
				if (r < 45) return MODE_PUSH;
				if (r < 75) return MODE_POP;
				if (r < 88) return MODE_TOP;
				return MODE_SECOND;
			end
		endcase
	endfunction

	task automatic run_phase(input int n_items, input int sender_idle, input int receiver_stall);
		int sent;
		int burst;
		bit paused;
		op_mix_e mix;
		logic [2:0] op;
		idle_pct = sender_idle;
		stall_pct = receiver_stall;
		sent = 0;
		paused = 1'b0;
		// Every phase opens with a run of pushes long enough to overflow the queue.
		mix = MIX_PUSH_ONLY;
		burst = $urandom_range(80, 70);
		while (sent < n_items) begin
			if (burst == 0) begin
				if (!paused && sent > n_items / 2) begin
					wait_drained();
					paused = 1'b1;
				end
				mix = op_mix_e'($urandom_range(MIX_PUSH_ONLY, MIX_BALANCED));
				burst = $urandom_range(120, 20);
			end
			op = pick_op(mix);
			send_op(op, pick_key(), ID_BITS'($urandom()));
			burst--;
			if (op <= MODE_CLEAR)
				sent++;
		end
		wait_drained();
	endtask

	initial begin
		shadow = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_op(MODE_POP, '0, '0);
		send_op(MODE_TOP, '0, '0);
		send_op(MODE_SECOND, '0, '0);
		send_op(MODE_PUSH, '1, '1);
		send_op(MODE_SECOND, '0, '0);
		send_op(MODE_PUSH, '0, '0);
		// Equal keys must queue behind the ones already stored.
		send_op(MODE_PUSH, '1, ID_BITS'(1));
		send_op(MODE_PUSH, '0, ID_BITS'(2));
		send_op(MODE_TOP, '0, '0);
		send_op(MODE_SECOND, '0, '0);
		send_op(MODE_IGNORED_5, '1, '1);
		send_op(3'(MODE_IGNORED_5 + 1), '1, '1);
		send_op(MODE_IGNORED_7, '1, '1);
		send_op(MODE_POP, '0, '0);
		send_op(MODE_POP, '0, '0);
		send_op(MODE_PUSH, {1'b1, {(KEY_BITS - 1){1'b0}}}, {1'b1, {(ID_BITS - 1){1'b0}}});
		wait_drained();
		send_op(MODE_CLEAR, '1, '1);
		send_op(MODE_TOP, '0, '0);
		send_op(MODE_POP, '0, '0);
		send_op(MODE_PUSH, KEY_BITS'(3), ID_BITS'(3));
		send_op(MODE_POP, '0, '0);
		wait_drained();

		run_phase(400, 0, 0);
		run_phase(350, 74, 0);
		run_phase(350, 0, 74);
		run_phase(300, 11, 11);

		stall_pct = 0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (shadow.expected_replies.size() != 0) begin
			$error("%0d expected results never arrived", shadow.expected_replies.size());
			shadow.errors++;
		end
		if (shadow.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### filelist.f
src/scpq_pkg.sv
src/scpq_cell.sv
src/sorted_cost_priority_queue_unit.sv
dv/tb_sorted_cost_priority_queue_unit.sv
